// ----- hdl/clock_page_replacement_macros.svh -----
// assertion macros shared by the clock page replacement rtl
`ifndef CLOCK_PAGE_REPLACEMENT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication, held off during reset
`define CPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpr assertion failed");

// next-cycle implication, held off during reset
`define CPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpr assertion failed");

`endif

// ----- hdl/cpr_pkg.sv -----
// shared types, codes and widths for the clock page replacement block
package cpr_pkg;

  localparam int WS_MAX_DEF        = 32;
  localparam int PAGE_NUM_BITS_DEF = 20;

  localparam int PAGE_W   = 20;
  localparam int SLOT_W   = 5;
  localparam int SIZE_W   = 6;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 3;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - (STATUS_W + SLOT_W + PAGE_W + 1);

  localparam logic [SIZE_W-1:0] WS_SIZE_RST = 6'd32;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WS_SIZE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_STACK_BOTTOM = 3'd1;
  localparam logic [IDX_W-1:0] REG_STACK_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_HEAP_START   = 3'd3;
  localparam logic [IDX_W-1:0] REG_HEAP_END     = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCESS  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd3;

  // classified command kinds
  localparam logic [1:0] KIND_ACCESS  = 2'd0;
  localparam logic [1:0] KIND_FAULT   = 2'd1;
  localparam logic [1:0] KIND_ILLEGAL = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] aslot;
    logic              wr;
  } cmd_t;

endpackage

// ----- hdl/cpr_ram.sv -----
// generic single write port ram with registered read
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/cpr_fifo.sv -----
// two entry command queue between front and back
module cpr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_data = mem[rptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end
endmodule

// ----- hdl/cpr_front.sv -----
// config registers, input word classification and fault legality check
module cpr_front #(
  parameter int PAGE_NUM_BITS = cpr_pkg::PAGE_NUM_BITS_DEF,
  parameter int WS_MAX        = cpr_pkg::WS_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cpr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [cpr_pkg::PAGE_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [0:0]                     s_tuser,
  input  logic [cpr_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           busy,
  input  logic                           q_full,
  output logic                           q_push,
  output cpr_pkg::cmd_t                  q_data,
  output logic [cpr_pkg::SIZE_W-1:0]     size
);
  localparam int PW   = (PAGE_NUM_BITS < cpr_pkg::PAGE_W) ? PAGE_NUM_BITS : cpr_pkg::PAGE_W;
  localparam int SMAX = (WS_MAX < 63) ? WS_MAX : 63;

  logic [cpr_pkg::SIZE_W-1:0] ws_size;
  logic [cpr_pkg::PAGE_W-1:0] stack_bottom;
  logic [cpr_pkg::PAGE_W-1:0] stack_top;
  logic [cpr_pkg::PAGE_W-1:0] heap_start;
  logic [cpr_pkg::PAGE_W-1:0] heap_end;

  logic [cpr_pkg::PAGE_W-1:0] page;
  logic                       in_pf;
  logic                       in_stack;
  logic                       in_heap;

  // no write while a word is in flight or offered on the input
  assign cfg_ready = !busy && !s_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ws_size      <= cpr_pkg::WS_SIZE_RST;
      stack_bottom <= '0;
      stack_top    <= '0;
      heap_start   <= '0;
      heap_end     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpr_pkg::REG_WS_SIZE:      ws_size      <= cfg_data[cpr_pkg::SIZE_W-1:0];
        cpr_pkg::REG_STACK_BOTTOM: stack_bottom <= cfg_data;
        cpr_pkg::REG_STACK_TOP:    stack_top    <= cfg_data;
        cpr_pkg::REG_HEAP_START:   heap_start   <= cfg_data;
        cpr_pkg::REG_HEAP_END:     heap_end     <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the slot count is clipped
  always_comb begin
    if (ws_size == '0) begin
      size = cpr_pkg::SIZE_W'(1);
    end else if (int'(ws_size) > SMAX) begin
      size = cpr_pkg::SIZE_W'(SMAX);
    end else begin
      size = ws_size;
    end
  end

  // page number held to the configured page width
  assign page     = cpr_pkg::PAGE_W'(PW'(s_tdata[19:0]));
  assign in_pf    = s_tdata[26];
  assign in_stack = (page >= stack_bottom) && (page < stack_top);
  assign in_heap  = (page >= heap_start) && (page < heap_end);

  always_comb begin
    q_data.page  = page;
    q_data.aslot = s_tdata[24:20];
    q_data.wr    = s_tdata[25];
    if (!s_tuser[0]) begin
      q_data.kind = cpr_pkg::KIND_ACCESS;
    end else if (in_pf || in_stack || in_heap) begin
      q_data.kind = cpr_pkg::KIND_FAULT;
    end else begin
      q_data.kind = cpr_pkg::KIND_ILLEGAL;
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
endmodule

// ----- hdl/cpr_back.sv -----
// slot marks, clock hand sweep, page store and result register
`include "clock_page_replacement_macros.svh"
module cpr_back #(
  parameter int WS_MAX        = cpr_pkg::WS_MAX_DEF,
  parameter int PAGE_NUM_BITS = cpr_pkg::PAGE_NUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cpr_pkg::SIZE_W-1:0]     size,
  input  logic                           q_empty,
  input  cpr_pkg::cmd_t                  q_data,
  output logic                           q_pop,
  output logic                           busy,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cpr_pkg::OUT_DATA_W-1:0] m_tdata
);
  localparam int SMAX = (WS_MAX < 63) ? WS_MAX : 63;
  localparam int SW   = (SMAX > 1) ? $clog2(SMAX) : 1;
  localparam int CW   = $clog2(SMAX + 1);
  localparam int PW   = (PAGE_NUM_BITS < cpr_pkg::PAGE_W) ? PAGE_NUM_BITS : cpr_pkg::PAGE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_VREAD = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]                   state;
  logic [SW-1:0]                hand;
  logic [CW-1:0]                count;
  logic [SMAX-1:0]              used;
  logic [SMAX-1:0]              modf;
  logic [cpr_pkg::PAGE_W-1:0]   cur_page;
  logic [cpr_pkg::STATUS_W-1:0] res_status;
  logic [cpr_pkg::SLOT_W-1:0]   res_slot;
  logic [cpr_pkg::PAGE_W-1:0]   res_victim;
  logic                         res_wb;

  logic [SW-1:0] hand_inc;
  logic [SW-1:0] aidx;
  logic [SW-1:0] cidx;
  logic          aslot_ok;
  logic          hand_big;
  logic          fill;
  logic          emit_ok;
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [PW-1:0] ram_rdata;

  // hand wraps at the working-set size
  assign hand_inc = ((cpr_pkg::SIZE_W'(hand) + cpr_pkg::SIZE_W'(1)) == size) ? '0
                  : hand + SW'(1);
  assign aidx     = SW'(q_data.aslot);
  assign cidx     = SW'(count);
  // resident slots always form a prefix, so count stands in for valid marks
  assign aslot_ok = (cpr_pkg::SIZE_W'(q_data.aslot) < size)
                 && (cpr_pkg::SIZE_W'(q_data.aslot) < cpr_pkg::SIZE_W'(count));
  assign hand_big = cpr_pkg::SIZE_W'(hand) >= size;
  assign fill     = cpr_pkg::SIZE_W'(count) < size;
  assign emit_ok  = !m_tvalid || m_tready;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign busy     = (state != S_IDLE) || !q_empty;

  assign ram_we    = ((state == S_MOD) && !hand_big && fill) || (state == S_VREAD);
  assign ram_waddr = (state == S_MOD) ? cidx : hand;

  cpr_ram #(
    .WIDTH (PW),
    .DEPTH (SMAX)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (PW'(cur_page)),
    .raddr (hand),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      hand     <= '0;
      count    <= '0;
      used     <= '0;
      modf     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_EMIT && emit_ok) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_data.kind == cpr_pkg::KIND_FAULT) begin
              state <= S_MOD;
            end else begin
              state <= S_EMIT;
              if (q_data.kind == cpr_pkg::KIND_ACCESS && aslot_ok) begin
                used[aidx] <= 1'b1;
                if (q_data.wr) modf[aidx] <= 1'b1;
              end
            end
          end
        end
        S_MOD: begin
          if (hand_big) begin
            hand <= SW'(cpr_pkg::SIZE_W'(hand) - size);
          end else if (fill) begin
            used[cidx] <= 1'b0;
            modf[cidx] <= 1'b0;
            count      <= count + CW'(1);
            hand       <= hand_inc;
            state      <= S_EMIT;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (used[hand]) begin
            used[hand] <= 1'b0;
            hand       <= hand_inc;
          end else begin
            state <= S_VREAD;
          end
        end
        S_VREAD: begin
          used[hand] <= 1'b0;
          modf[hand] <= 1'b0;
          hand       <= hand_inc;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          cur_page   <= q_data.page;
          res_victim <= '0;
          res_wb     <= 1'b0;
          if (q_data.kind == cpr_pkg::KIND_ACCESS) begin
            res_status <= cpr_pkg::ST_ACCESS;
            res_slot   <= q_data.aslot;
          end else begin
            res_status <= cpr_pkg::ST_ILLEGAL;
            res_slot   <= '0;
          end
        end
      end
      S_MOD: begin
        if (!hand_big && fill) begin
          res_status <= cpr_pkg::ST_FILLED;
          res_slot   <= cpr_pkg::SLOT_W'(cidx);
        end
      end
      S_VREAD: begin
        res_status <= cpr_pkg::ST_REPLACE;
        res_slot   <= cpr_pkg::SLOT_W'(hand);
        res_victim <= cpr_pkg::PAGE_W'(ram_rdata);
        res_wb     <= modf[hand];
      end
      S_EMIT: begin
        if (emit_ok) begin
          m_tdata <= {{cpr_pkg::OUT_PAD_W{1'b0}}, res_wb, res_victim, res_slot, res_status};
        end
      end
      default: ;
    endcase
  end

  `CPR_ASSERT_IMP(a_sweep_only_when_full, clk, rst, state == S_SWEEP, cpr_pkg::SIZE_W'(count) >= size)
  `CPR_ASSERT_NEXT(a_fill_bumps_count, clk, rst, state == S_MOD && !hand_big && fill, count == $past(count) + CW'(1))
  `CPR_ASSERT_IMP(a_hand_below_size, clk, rst, state == S_SWEEP || state == S_VREAD, cpr_pkg::SIZE_W'(hand) < size)
endmodule

// ----- hdl/clock_page_replacement.sv -----
// top level of the clock (second chance) page replacement block
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tuser: op; s_tdata: page, slot, flags
//  m_       | out       | m_tvalid / m_tready  | m_tdata: status, slot, victim, writeback
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// an access or an illegal fault goes from idle straight to emit; a legal fault first takes
// the hand back by the size while it lies at or past a shrunk size, then fills a free slot
// or sweeps to an unmarked slot, clearing at most size used marks, and reads its victim page
// the two entry queue keeps taking words, until full, while the back end sweeps or the result waits
// reset is synchronous and clears the marks, the hand and the resident count; no ram clearing
// config writes wait on cfg_ready while any word is in flight or offered on the input
module clock_page_replacement #(
  parameter int WS_MAX        = cpr_pkg::WS_MAX_DEF,
  parameter int PAGE_NUM_BITS = cpr_pkg::PAGE_NUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cpr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [cpr_pkg::PAGE_W-1:0]     cfg_data,
  // input words
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [0:0]                     s_tuser,  // [0] op: 0 access, 1 page fault
  input  logic [cpr_pkg::IN_DATA_W-1:0]  s_tdata,  // page_number[19:0], access_slot[24:20],
                                                   // is_write[25], in_page_file[26], zero pad
  // result words
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cpr_pkg::OUT_DATA_W-1:0] m_tdata   // status[1:0], slot[6:2],
                                                   // victim_page[26:7], victim_writeback[27]
);
  cpr_pkg::cmd_t              push_cmd;
  cpr_pkg::cmd_t              head_cmd;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  logic                       busy;
  logic [cpr_pkg::SIZE_W-1:0] size;

  // front: config registers and classification of each word
  cpr_front #(
    .PAGE_NUM_BITS (PAGE_NUM_BITS),
    .WS_MAX        (WS_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_cmd),
    .size      (size)
  );

  // short queue so the front keeps taking words while the sweep runs, until it fills
  cpr_fifo #(
    .WIDTH ($bits(cpr_pkg::cmd_t))
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .empty     (q_empty)
  );

  // back: marks, clock hand, page store and the result register
  cpr_back #(
    .WS_MAX        (WS_MAX),
    .PAGE_NUM_BITS (PAGE_NUM_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .size     (size),
    .q_empty  (q_empty),
    .q_data   (head_cmd),
    .q_pop    (q_pop),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );
endmodule
